FILE: src/debounced_lap_stopwatch_core_macros.svh
// Assertion macros shared by the stopwatch checker.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef DEBOUNCED_LAP_STOPWATCH_CORE_MACROS_SVH
`define DEBOUNCED_LAP_STOPWATCH_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define DLS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define DLS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/dls_pkg.sv
// Shared constants and types of the lap stopwatch core.
// No dependencies.
package dls_pkg;

    localparam int LANES_DEF       = 3;
    localparam int HOLD_REPEAT_DEF = 100;
    localparam int FIXED_INPUTS    = 2;

    localparam int HIST_W  = 8;
    localparam int HOLD_W  = 16;
    localparam int LIMIT_W = 4;
    localparam int TOTAL_W = 20;
    localparam int HUND_W  = 7;
    localparam int SEC_W   = 6;
    localparam int MIN_W   = 7;

    localparam logic [HIST_W-1:0]  HIST_FIRE = 8'h03;
    localparam logic [HIST_W-1:0]  HIST_IDLE = 8'hFF;

    localparam logic [HUND_W-1:0]  HUND_WRAP  = 7'd100;
    localparam logic [SEC_W-1:0]   SEC_WRAP   = 6'd60;
    localparam logic [MIN_W-1:0]   MIN_WRAP   = 7'd100;
    localparam logic [TOTAL_W-1:0] TOTAL_WRAP = 20'd600000;

    localparam logic [HOLD_W-1:0]  HOLD_TIMEOUT_RST = 16'd500;
    localparam logic [LIMIT_W-1:0] LAP_LIMIT_RST    = 4'd5;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SCAN = 1'b1;

    localparam logic REG_HOLD_TIMEOUT = 1'b0;
    localparam logic REG_LAP_LIMIT    = 1'b1;

    typedef struct packed {
        logic fire;
        logic toggle;
    } dls_btn_t;

    typedef struct packed {
        logic clr;
        logic ev;
    } dls_lane_ctl_t;

endpackage

FILE: src/debounced_lap_stopwatch_core.sv
// Lap stopwatch core: throughput one transaction per cycle while the output
// is not stalled; the input register feeds the state update, and the updated
// state registers are the result held for the output. Input stalls only
// while a result waits and the input register is full.
// Asynchronous active-low reset: clock stopped at zero, debouncers idle,
// hold_timeout 500, lap_limit 5, no transaction pending.
module debounced_lap_stopwatch_core #(
    parameter int LANES       = dls_pkg::LANES_DEF,
    parameter int HOLD_REPEAT = dls_pkg::HOLD_REPEAT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dls_pkg::ADDR_W-1:0]   paddr,
    input  logic [dls_pkg::DATA_W-1:0]   pwdata,
    output logic [dls_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         op,
    input  logic                         run_stop_level,
    input  logic                         reset_level,
    input  logic                         lane_a_level,
    input  logic                         lane_b_level,
    input  logic                         lane_c_level,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         running,
    output logic [dls_pkg::MIN_W-1:0]    now_minutes,
    output logic [dls_pkg::SEC_W-1:0]    now_seconds,
    output logic [dls_pkg::HUND_W-1:0]   now_hundredths,
    output logic                         led_level,
    output logic [dls_pkg::LIMIT_W-1:0]  laps_a,
    output logic [dls_pkg::LIMIT_W-1:0]  laps_b,
    output logic [dls_pkg::LIMIT_W-1:0]  laps_c,
    output logic [dls_pkg::TOTAL_W-1:0]  split_a,
    output logic [dls_pkg::TOTAL_W-1:0]  split_b,
    output logic [dls_pkg::TOTAL_W-1:0]  split_c
);

    localparam int NUM_IN = dls_pkg::FIXED_INPUTS + LANES;
    localparam int IDX_B  = (LANES > 1) ? 1 : 0;
    localparam int IDX_C  = (LANES > 2) ? 2 : 0;

    logic [dls_pkg::HOLD_W-1:0]  hold_timeout_reg;
    logic [dls_pkg::LIMIT_W-1:0] lap_limit_reg;
    logic                        cfg_wr;

    logic       s1_valid_reg, s1_valid_next;
    logic       s1_op_reg;
    logic [4:0] s1_lvl_reg;
    logic       out_valid_reg, out_valid_next;
    logic       out_free, go, in_accept, scan_en, tick_en;

    logic [NUM_IN-1:0]     lvl;
    dls_pkg::dls_btn_t     btn [NUM_IN];
    logic [NUM_IN-1:0]     toggles;

    logic                        run_reg, run_next;
    logic                        led_reg;
    logic [dls_pkg::HUND_W-1:0]  hund_reg, hund_next;
    logic [dls_pkg::SEC_W-1:0]   sec_reg, sec_next;
    logic [dls_pkg::MIN_W-1:0]   min_reg, min_next;
    logic [dls_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic                        clear_all;
    logic [dls_pkg::TOTAL_W-1:0] lane_total;

    dls_pkg::dls_lane_ctl_t      lane_ctl [LANES];
    logic [dls_pkg::TOTAL_W-1:0] lane_split [LANES];
    logic [dls_pkg::LIMIT_W-1:0] lane_laps [LANES];

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[2])
            dls_pkg::REG_HOLD_TIMEOUT: prdata = dls_pkg::DATA_W'(hold_timeout_reg);
            dls_pkg::REG_LAP_LIMIT:    prdata = dls_pkg::DATA_W'(lap_limit_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_timeout_reg <= dls_pkg::HOLD_TIMEOUT_RST;
            lap_limit_reg    <= dls_pkg::LAP_LIMIT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                dls_pkg::REG_HOLD_TIMEOUT:
                    hold_timeout_reg <= pwdata[dls_pkg::HOLD_W-1:0];
                dls_pkg::REG_LAP_LIMIT:
                    lap_limit_reg <= pwdata[dls_pkg::LIMIT_W-1:0];
            endcase
        end
    end

    // Handshake and input register
    assign out_free  = !out_valid_reg || !out_stall;
    assign go        = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;
    assign scan_en   = go && (s1_op_reg == dls_pkg::OP_SCAN);
    assign tick_en   = go && (s1_op_reg == dls_pkg::OP_TICK) && run_reg;

    always_comb
    begin
        s1_valid_next  = in_accept ? 1'b1 : (go ? 1'b0 : s1_valid_reg);
        out_valid_next = go ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg  <= op;
            s1_lvl_reg <= {lane_c_level, lane_b_level, lane_a_level,
                           reset_level, run_stop_level};
        end
    end

    // Debouncers
    assign lvl[0] = s1_lvl_reg[0];
    assign lvl[1] = s1_lvl_reg[1];

    for (genvar i = 0; i < LANES; i++)
    begin : g_lvl
        if (i < 3)
        begin : g_pin
            assign lvl[dls_pkg::FIXED_INPUTS+i] = s1_lvl_reg[dls_pkg::FIXED_INPUTS+i];
        end
        else
        begin : g_idle
            assign lvl[dls_pkg::FIXED_INPUTS+i] = 1'b1;
        end
    end

    for (genvar k = 0; k < NUM_IN; k++)
    begin : g_deb
        dls_debounce #(
            .HOLD_REPEAT (HOLD_REPEAT)
        ) u_deb (
            .clk          (clk),
            .rst_n        (rst_n),
            .en           (scan_en),
            .level        (lvl[k]),
            .hold_timeout (hold_timeout_reg),
            .btn          (btn[k])
        );
        assign toggles[k] = btn[k].toggle;
    end

    // Stopwatch clock
    assign clear_all  = scan_en && btn[1].fire;
    assign lane_total = clear_all ? '0 : total_reg;

    always_comb
    begin
        hund_next  = hund_reg;
        sec_next   = sec_reg;
        min_next   = min_reg;
        total_next = total_reg;
        run_next   = run_reg;
        if (tick_en)
        begin
            hund_next = hund_reg + 1'b1;
            if (hund_next >= dls_pkg::HUND_WRAP)
            begin
                hund_next = '0;
                sec_next  = sec_reg + 1'b1;
            end
            if (sec_next >= dls_pkg::SEC_WRAP)
            begin
                sec_next = '0;
                min_next = min_reg + 1'b1;
            end
            if (min_next >= dls_pkg::MIN_WRAP)
            begin
                hund_next = '0;
                sec_next  = '0;
                min_next  = '0;
            end
            total_next = total_reg + 1'b1;
            if (total_next >= dls_pkg::TOTAL_WRAP)
                total_next = '0;
        end
        if (scan_en && btn[0].fire)
            run_next = !run_reg;
        if (clear_all)
        begin
            run_next   = 1'b0;
            hund_next  = '0;
            sec_next   = '0;
            min_next   = '0;
            total_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            led_reg   <= 1'b0;
            hund_reg  <= '0;
            sec_reg   <= '0;
            min_reg   <= '0;
            total_reg <= '0;
        end
        else if (go)
        begin
            run_reg   <= run_next;
            led_reg   <= led_reg ^ (scan_en & (^toggles));
            hund_reg  <= hund_next;
            sec_reg   <= sec_next;
            min_reg   <= min_next;
            total_reg <= total_next;
        end
    end

    // Lanes
    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        assign lane_ctl[i].clr = clear_all;
        assign lane_ctl[i].ev  = scan_en && btn[dls_pkg::FIXED_INPUTS+i].fire;

        dls_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (lane_ctl[i]),
            .total     (lane_total),
            .lap_limit (lap_limit_reg),
            .split     (lane_split[i]),
            .laps      (lane_laps[i])
        );
    end

    // Result
    assign out_valid      = out_valid_reg;
    assign running        = run_reg;
    assign now_minutes    = min_reg;
    assign now_seconds    = sec_reg;
    assign now_hundredths = hund_reg;
    assign led_level      = led_reg;
    assign laps_a         = lane_laps[0];
    assign split_a        = lane_split[0];
    assign laps_b         = (LANES > 1) ? lane_laps[IDX_B] : '0;
    assign split_b        = (LANES > 1) ? lane_split[IDX_B] : '0;
    assign laps_c         = (LANES > 2) ? lane_laps[IDX_C] : '0;
    assign split_c        = (LANES > 2) ? lane_split[IDX_C] : '0;

endmodule

FILE: src/dls_debounce.sv
// Shift debouncer with hold timeout for one active-low input.
// Depends on dls_pkg.
module dls_debounce #(
    parameter int HOLD_REPEAT = dls_pkg::HOLD_REPEAT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        level,
    input  logic [dls_pkg::HOLD_W-1:0]  hold_timeout,
    output dls_pkg::dls_btn_t           btn
);

    localparam int SUM_W = $clog2((2 ** dls_pkg::HOLD_W) + HOLD_REPEAT + 2);
    localparam logic [SUM_W-1:0] REPEAT_EXT = SUM_W'(HOLD_REPEAT);

    logic [dls_pkg::HIST_W-1:0] hist_reg, hist_next;
    logic [dls_pkg::HOLD_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0]           bump;
    logic [SUM_W-1:0]           lim;
    logic                       pressed;
    logic                       in_hold;

    always_comb
    begin
        pressed    = ~level;
        in_hold    = cnt_reg > hold_timeout;
        bump       = SUM_W'(cnt_reg) + SUM_W'(2);
        lim        = SUM_W'(hold_timeout) + REPEAT_EXT;
        hist_next  = hist_reg;
        cnt_next   = cnt_reg;
        btn.toggle = 1'b0;
        if (pressed && !in_hold)
        begin
            hist_next = {hist_reg[dls_pkg::HIST_W-2:0], 1'b0};
            cnt_next  = cnt_reg + 1'b1;
        end
        else if (pressed)
        begin
            if (bump >= lim)
            begin
                cnt_next   = hold_timeout + 1'b1;
                btn.toggle = 1'b1;
            end
            else
            begin
                cnt_next = bump[dls_pkg::HOLD_W-1:0];
            end
        end
        else if (!in_hold)
        begin
            hist_next = {hist_reg[dls_pkg::HIST_W-2:0], 1'b1};
            cnt_next  = '0;
        end
        else
        begin
            hist_next = dls_pkg::HIST_IDLE;
            cnt_next  = '0;
        end
        btn.fire = hist_next == dls_pkg::HIST_FIRE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= dls_pkg::HIST_IDLE;
            cnt_reg  <= '0;
        end
        else if (en)
        begin
            hist_reg <= hist_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

FILE: src/dls_lane.sv
// Per-lane stamp, split and saturating lap count.
// Depends on dls_pkg.
module dls_lane (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dls_pkg::dls_lane_ctl_t       ctl,
    input  logic [dls_pkg::TOTAL_W-1:0]  total,
    input  logic [dls_pkg::LIMIT_W-1:0]  lap_limit,
    output logic [dls_pkg::TOTAL_W-1:0]  split,
    output logic [dls_pkg::LIMIT_W-1:0]  laps
);

    logic [dls_pkg::TOTAL_W-1:0] stamp_reg, stamp_next;
    logic [dls_pkg::TOTAL_W-1:0] split_reg, split_next;
    logic [dls_pkg::LIMIT_W-1:0] laps_reg, laps_next;
    logic [dls_pkg::TOTAL_W-1:0] stamp_base;
    logic [dls_pkg::LIMIT_W-1:0] laps_base;
    logic [dls_pkg::TOTAL_W:0]   diff;
    logic [dls_pkg::LIMIT_W:0]   inc;

    always_comb
    begin
        stamp_base = ctl.clr ? '0 : stamp_reg;
        laps_base  = ctl.clr ? '0 : laps_reg;
        diff       = {1'b0, total} - {1'b0, stamp_base};
        inc        = {1'b0, laps_base} + 1'b1;
        stamp_next = stamp_base;
        split_next = ctl.clr ? '0 : split_reg;
        laps_next  = laps_base;
        if (ctl.ev)
        begin
            stamp_next = total;
            if (diff[dls_pkg::TOTAL_W])
                split_next = diff[dls_pkg::TOTAL_W-1:0] + dls_pkg::TOTAL_WRAP;
            else
                split_next = diff[dls_pkg::TOTAL_W-1:0];
            if (inc >= {1'b0, lap_limit})
                laps_next = lap_limit;
            else
                laps_next = inc[dls_pkg::LIMIT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stamp_reg <= '0;
            split_reg <= '0;
            laps_reg  <= '0;
        end
        else if (ctl.ev || ctl.clr)
        begin
            stamp_reg <= stamp_next;
            split_reg <= split_next;
            laps_reg  <= laps_next;
        end
    end

    assign split = split_reg;
    assign laps  = laps_reg;

endmodule

FILE: src/dls_checker.sv
// Port-level checker for the lap stopwatch core, bound to the top level.
// Depends on dls_pkg and debounced_lap_stopwatch_core_macros.svh.
`include "debounced_lap_stopwatch_core_macros.svh"

module dls_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [dls_pkg::MIN_W-1:0]    now_minutes,
    input logic [dls_pkg::SEC_W-1:0]    now_seconds,
    input logic [dls_pkg::HUND_W-1:0]   now_hundredths,
    input logic [dls_pkg::TOTAL_W-1:0]  split_a
);

    `DLS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

    `DLS_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without backpressure")

    `DLS_ASSERT_NOW(a_clock_range, out_valid, (now_hundredths < dls_pkg::HUND_WRAP) && (now_seconds < dls_pkg::SEC_WRAP) && (now_minutes < dls_pkg::MIN_WRAP), "clock digit out of range")

    `DLS_ASSERT_NOW(a_split_range, out_valid, split_a < dls_pkg::TOTAL_WRAP, "split out of range")

endmodule

bind debounced_lap_stopwatch_core dls_checker u_dls_checker (.*);

FILE: tb/tb_debounced_lap_stopwatch_core.sv
// Self-checking testbench for debounced_lap_stopwatch_core: random press patterns,
// ticks and APB register phases, checked against a scoreboard predictor.
// Depends on dls_pkg and the core RTL.
`timescale 1ns / 1ps

import dls_pkg::*;

localparam int NUM_IN    = FIXED_INPUTS + LANES_DEF;
localparam int IN_RUN    = 0;
localparam int IN_RESET  = 1;
localparam int IN_LANE_A = 2;
localparam int IN_LANE_B = 3;
localparam int IN_LANE_C = 4;

typedef struct packed {
    logic              op;
    logic [NUM_IN-1:0] levels;
} sample_t;

typedef struct packed {
    logic               running;
    logic [MIN_W-1:0]   minutes;
    logic [SEC_W-1:0]   seconds;
    logic [HUND_W-1:0]  hundredths;
    logic               led;
    logic [LIMIT_W-1:0] laps_a;
    logic [LIMIT_W-1:0] laps_b;
    logic [LIMIT_W-1:0] laps_c;
    logic [TOTAL_W-1:0] split_a;
    logic [TOTAL_W-1:0] split_b;
    logic [TOTAL_W-1:0] split_c;
} readout_t;

class lap_scoreboard;
    int unsigned        hold_limit;
    int unsigned        lap_cap;
    logic               run_flag;
    logic [HUND_W-1:0]  hund;
    logic [SEC_W-1:0]   sec;
    logic [MIN_W-1:0]   mins;
    logic [TOTAL_W-1:0] total;
    logic [HIST_W-1:0]  hist [NUM_IN];
    logic [HOLD_W-1:0]  hold_cnt [NUM_IN];
    logic [TOTAL_W-1:0] stamp [LANES_DEF];
    logic [TOTAL_W-1:0] split [LANES_DEF];
    logic [LIMIT_W-1:0] laps [LANES_DEF];
    logic               led;
    readout_t           expected_readouts [$];
    int unsigned        fail_count;

    function new();
        hold_limit = HOLD_TIMEOUT_RST;
        lap_cap    = LAP_LIMIT_RST;
        clear_times();
        for (int k = 0; k < NUM_IN; k++)
        begin
            hist[k]     = HIST_IDLE;
            hold_cnt[k] = '0;
        end
        led        = 1'b0;
        fail_count = 0;
    endfunction

    function void set_config(logic idx, logic [DATA_W-1:0] val);
        if (idx == REG_HOLD_TIMEOUT)
            hold_limit = val[HOLD_W-1:0];
        else
            lap_cap = val[LIMIT_W-1:0];
    endfunction

    function void clear_times();
        run_flag = 1'b0;
        hund     = '0;
        sec      = '0;
        mins     = '0;
        total    = '0;
        for (int i = 0; i < LANES_DEF; i++)
        begin
            stamp[i] = '0;
            split[i] = '0;
            laps[i]  = '0;
        end
    endfunction

    function void advance_clock();
        if (!run_flag)
            return;
        hund = hund + 1'b1;
        if (hund >= HUND_WRAP)
        begin
            hund = '0;
            sec  = sec + 1'b1;
        end
        if (sec >= SEC_WRAP)
        begin
            sec  = '0;
            mins = mins + 1'b1;
        end
        if (mins >= MIN_WRAP)
        begin
            hund = '0;
            sec  = '0;
            mins = '0;
        end
        total = total + 1'b1;
        if (total >= TOTAL_WRAP)
            total = '0;
    endfunction

    // Returns 1 when the input's debounced event fires.
    function bit debounce_step(int k, bit pressed);
        int unsigned       t;
        int unsigned       c;
        int unsigned       n;
        logic [HIST_W-1:0] h;
        t = hold_limit;
        c = hold_cnt[k];
        h = hist[k];
        if (pressed && c <= t)
        begin
            h = {h[HIST_W-2:0], 1'b0};
            c = (c + 1) & 32'hFFFF;
        end
        else if (pressed)
        begin
            n = c + 2;
            if (n >= t + HOLD_REPEAT_DEF)
            begin
                n   = t + 1;
                led = !led;
            end
            c = n & 32'hFFFF;
        end
        else if (c <= t)
        begin
            h = {h[HIST_W-2:0], 1'b1};
            c = 0;
        end
        else
        begin
            c = 0;
            h = HIST_IDLE;
        end
        hold_cnt[k] = c[HOLD_W-1:0];
        hist[k]     = h;
        return h == HIST_FIRE;
    endfunction

    function void lane_event(int i);
        int unsigned span;
        int unsigned next;
        span     = 32'(total) + 32'(TOTAL_WRAP) - 32'(stamp[i]);
        split[i] = TOTAL_W'(span % 32'(TOTAL_WRAP));
        stamp[i] = total;
        next     = 32'(laps[i]) + 1;
        laps[i]  = (next >= lap_cap) ? LIMIT_W'(lap_cap) : LIMIT_W'(next);
    endfunction

    function void note_input(sample_t s);
        readout_t want;
        if (s.op == OP_TICK)
            advance_clock();
        else
        begin
            if (debounce_step(IN_RUN, !s.levels[IN_RUN]))
                run_flag = !run_flag;
            if (debounce_step(IN_RESET, !s.levels[IN_RESET]))
                clear_times();
            for (int i = 0; i < LANES_DEF; i++)
                if (debounce_step(IN_LANE_A + i, !s.levels[IN_LANE_A + i]))
                    lane_event(i);
        end
        want.running    = run_flag;
        want.minutes    = mins;
        want.seconds    = sec;
        want.hundredths = hund;
        want.led        = led;
        want.laps_a     = laps[0];
        want.laps_b     = laps[1];
        want.laps_c     = laps[2];
        want.split_a    = split[0];
        want.split_b    = split[1];
        want.split_c    = split[2];
        expected_readouts.push_back(want);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    function void check_result(readout_t got);
        readout_t want;
        if (expected_readouts.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            fail_count++;
            return;
        end
        want = expected_readouts.pop_front();
        compare_field("running", want.running, got.running);
        compare_field("now_minutes", want.minutes, got.minutes);
        compare_field("now_seconds", want.seconds, got.seconds);
        compare_field("now_hundredths", want.hundredths, got.hundredths);
        compare_field("led_level", want.led, got.led);
        compare_field("laps_a", want.laps_a, got.laps_a);
        compare_field("laps_b", want.laps_b, got.laps_b);
        compare_field("laps_c", want.laps_c, got.laps_c);
        compare_field("split_a", want.split_a, got.split_a);
        compare_field("split_b", want.split_b, got.split_b);
        compare_field("split_c", want.split_c, got.split_c);
    endfunction
endclass

module tb_debounced_lap_stopwatch_core;

    localparam int PHASES         = 7;
    localparam int RAND_PER_PHASE = 270;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               op = OP_TICK;
    logic               run_stop_level = 1'b1;
    logic               reset_level = 1'b1;
    logic               lane_a_level = 1'b1;
    logic               lane_b_level = 1'b1;
    logic               lane_c_level = 1'b1;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               running;
    logic [MIN_W-1:0]   now_minutes;
    logic [SEC_W-1:0]   now_seconds;
    logic [HUND_W-1:0]  now_hundredths;
    logic               led_level;
    logic [LIMIT_W-1:0] laps_a;
    logic [LIMIT_W-1:0] laps_b;
    logic [LIMIT_W-1:0] laps_c;
    logic [TOTAL_W-1:0] split_a;
    logic [TOTAL_W-1:0] split_b;
    logic [TOTAL_W-1:0] split_c;

    lap_scoreboard sb;
    bit            steady = 1'b0;
    int unsigned   cur_hold = HOLD_TIMEOUT_RST;
    int            press_left [NUM_IN];
    int            gap_left [NUM_IN];

    int unsigned hold_tab [PHASES] = '{500, 30, 9, 60000, 1, 16, 65535};
    int unsigned lim_tab [PHASES]  = '{5, 15, 2, 1, 15, 0, 7};

    debounced_lap_stopwatch_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .run_stop_level (run_stop_level),
        .reset_level    (reset_level),
        .lane_a_level   (lane_a_level),
        .lane_b_level   (lane_b_level),
        .lane_c_level   (lane_c_level),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .running        (running),
        .now_minutes    (now_minutes),
        .now_seconds    (now_seconds),
        .now_hundredths (now_hundredths),
        .led_level      (led_level),
        .laps_a         (laps_a),
        .laps_b         (laps_b),
        .laps_c         (laps_c),
        .split_a        (split_a),
        .split_b        (split_b),
        .split_c        (split_c)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit take_gap();
        return !steady && ($urandom_range(99) < 38);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(readout_t'({running, now_minutes, now_seconds, now_hundredths,
                                        led_level, laps_a, laps_b, laps_c,
                                        split_a, split_b, split_c}));
        out_stall <= take_gap();
    end

    task automatic apb_write(input logic idx, input logic [DATA_W-1:0] val);
        logic [DATA_W-1:0] want;
        want = (idx == REG_HOLD_TIMEOUT) ? (val & 32'hFFFF) : (val & 32'hF);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
        begin
            $display("%0t: register %0d readback mismatch, expected %0d, actual %0d",
                     $time, idx, want, prdata);
            sb.fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        sb.set_config(idx, val);
    endtask

    task automatic push_item(input sample_t s);
        while (take_gap())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        op             <= s.op;
        run_stop_level <= s.levels[IN_RUN];
        reset_level    <= s.levels[IN_RESET];
        lane_a_level   <= s.levels[IN_LANE_A];
        lane_b_level   <= s.levels[IN_LANE_B];
        lane_c_level   <= s.levels[IN_LANE_C];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(s);
    endtask

    task automatic push_tick();
        sample_t s;
        s.op     = OP_TICK;
        s.levels = NUM_IN'($urandom);
        push_item(s);
    endtask

    // Hold the masked inputs long enough to debounce, then release twice to fire.
    task automatic press_release(input logic [NUM_IN-1:0] mask);
        sample_t s;
        s.op     = OP_SCAN;
        s.levels = ~mask;
        repeat (6) push_item(s);
        s.levels = '1;
        repeat (2) push_item(s);
    endtask

    task automatic make_scan(output logic [NUM_IN-1:0] lv);
        int unsigned roll;
        int unsigned len;
        for (int k = 0; k < NUM_IN; k++)
        begin
            if (press_left[k] > 0)
            begin
                lv[k] = 1'b0;
                press_left[k]--;
            end
            else if (gap_left[k] > 0)
            begin
                lv[k] = 1'b1;
                gap_left[k]--;
            end
            else
            begin
                roll = $urandom_range(99);
                if (roll < 70)
                    len = $urandom_range(10, 6);
                else if (roll < 85 || cur_hold > 60)
                    len = $urandom_range(5, 1);
                else
                    len = cur_hold + $urandom_range(160, 1);
                lv[k]         = 1'b0;
                press_left[k] = len - 1;
                gap_left[k]   = (k == IN_RESET) ? $urandom_range(150, 30)
                                                : $urandom_range(12, 1);
            end
        end
        if ($urandom_range(99) < 10)
            lv = NUM_IN'($urandom);
    endtask

    initial
    begin
        sample_t s;
        sb = new();
        for (int k = 0; k < NUM_IN; k++)
        begin
            press_left[k] = 0;
            gap_left[k]   = $urandom_range(8);
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int ph = 0; ph < PHASES; ph++)
        begin
            steady = (ph == 1);
            apb_write(REG_HOLD_TIMEOUT, hold_tab[ph]);
            apb_write(REG_LAP_LIMIT, lim_tab[ph]);
            cur_hold = hold_tab[ph];
            if (ph == 0)
            begin
                push_tick();
                press_release(NUM_IN'((1 << IN_RUN) | (1 << IN_LANE_A)));
                repeat (3) push_tick();
                press_release(NUM_IN'((1 << IN_RUN) | (1 << IN_RESET) |
                                      (1 << IN_LANE_B) | (1 << IN_LANE_C)));
                push_tick();
            end
            repeat (RAND_PER_PHASE)
            begin
                s.op = ($urandom_range(99) < 50) ? OP_SCAN : OP_TICK;
                if (s.op == OP_SCAN)
                    make_scan(s.levels);
                else
                    s.levels = NUM_IN'($urandom);
                push_item(s);
            end
            in_valid <= 1'b0;
            while (sb.expected_readouts.size() != 0)
                @(posedge clk);
            repeat (4) @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (sb.fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
